// ----- hw/rtl/rts_pkg.sv -----
// rts_pkg: shared types, codes and helper functions for the rtf token scanner
// no dependencies; used by every module under hw/rtl
package rts_pkg;

   localparam int MAX_NAME_LETTERS   = 32;
   localparam int LETTER_COUNT_WIDTH = $clog2(MAX_NAME_LETTERS + 1);
   localparam int QUEUE_DEPTH        = 4;
   localparam int QUEUE_PTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_OPEN   = 3'd0;
   localparam logic [2:0] KIND_CLOSE  = 3'd1;
   localparam logic [2:0] KIND_LETTER = 3'd2;
   localparam logic [2:0] KIND_WEND   = 3'd3;
   localparam logic [2:0] KIND_SYMBOL = 3'd4;
   localparam logic [2:0] KIND_HEX    = 3'd5;
   localparam logic [2:0] KIND_TEXT   = 3'd6;
   localparam logic [2:0] KIND_BINARY = 3'd7;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_WORD   = 3'd2;
   localparam logic [2:0] MODE_NEG    = 3'd3;
   localparam logic [2:0] MODE_DIGITS = 3'd4;
   localparam logic [2:0] MODE_HEX1   = 3'd5;
   localparam logic [2:0] MODE_HEX2   = 3'd6;
   localparam logic [2:0] MODE_BIN    = 3'd7;

   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_MINUS     = 8'h2d;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_OPEN      = 8'h7b;
   localparam logic [7:0] CHAR_CLOSE     = 8'h7d;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_I         = 8'h69;
   localparam logic [7:0] CHAR_N         = 8'h6e;

   localparam logic [31:0] PARAM_POS_LIMIT = 32'h7fff_ffff;
   localparam logic [31:0] PARAM_MAG_LIMIT = 32'h8000_0000;
   localparam logic [3:0]  NIBBLE_OFFSET   = 4'd9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         token_kind;
      logic [7:0]         token_byte;
      logic               has_param;
      logic signed [31:0] param_value;
      logic               last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic            two_tokens;
      rsp_payload_type first_token;
      rsp_payload_type second_token;
   } queue_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic rsp_payload_type make_token(input logic [2:0] kind,
                                                  input logic [7:0] value,
                                                  input logic hp,
                                                  input logic [31:0] pv);
      rsp_payload_type t;
      t.token_kind  = kind;
      t.token_byte  = value;
      t.has_param   = hp;
      t.param_value = pv;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      return c[4] ? c[3:0] : (c[3:0] + NIBBLE_OFFSET);
   endfunction

   function automatic logic [7:0] bin_letter(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0: r = CHAR_B;
         2'd1: r = CHAR_I;
         default: r = CHAR_N;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/rts_front.sv -----
// rts_front: accepts stream bytes, runs the scan state machine, builds token pairs
// depends on rts_pkg; pushes into rts_queue
module rts_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rts_pkg::req_payload_type  req_data,
   input  rts_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output rts_pkg::queue_entry_type  push_entry
);

   logic [2:0]                             mode_ff, mode_in;
   logic [rts_pkg::LETTER_COUNT_WIDTH-1:0] letter_count_ff, letter_count_in;
   logic [1:0]                             name_match_ff, name_match_in;
   logic [31:0]                            param_accum_ff, param_accum_in;
   logic                                   param_negative_ff, param_negative_in;
   logic                                   digits_seen_ff, digits_seen_in;
   logic [7:0]                             hex_accum_ff, hex_accum_in;
   logic [30:0]                            binary_remaining_ff, binary_remaining_in;

   logic                      accept;
   logic [7:0]                c;
   logic                      at_end;
   rts_pkg::rsp_payload_type  tok_list [2];
   logic [1:0]                tok_count;
   logic                      do_finish, do_idle, do_bin;
   logic [30:0]               bin_base;
   logic [30:0]               bin_left;
   logic [35:0]               digit_sum;
   logic [31:0]               digit_accum;
   logic [31:0]               word_value;
   logic [30:0]               bin_start;
   logic                      is_bin_word;
   logic [7:0]                hex_value;

   assign accept    = req_valid && req_ready;
   assign req_ready = !queue_status.full;
   assign c         = req_data.data_byte;
   assign at_end    = req_data.end_of_input;

   assign digit_sum = ({4'd0, param_accum_ff} << 3) + ({4'd0, param_accum_ff} << 1)
                      + {32'd0, c[3:0]};
   assign digit_accum = (digit_sum > {4'd0, rts_pkg::PARAM_MAG_LIMIT}) ?
                        rts_pkg::PARAM_MAG_LIMIT : digit_sum[31:0];
   assign word_value = param_negative_ff ? (32'd0 - param_accum_ff) :
                       ((param_accum_ff > rts_pkg::PARAM_POS_LIMIT) ?
                        rts_pkg::PARAM_POS_LIMIT : param_accum_ff);
   assign bin_start = (param_accum_ff > rts_pkg::PARAM_POS_LIMIT) ?
                      rts_pkg::PARAM_POS_LIMIT[30:0] : param_accum_ff[30:0];
   assign is_bin_word = (int'(letter_count_ff) == 3) && (name_match_ff == 2'd3);
   assign hex_value = at_end ? hex_accum_ff : {hex_accum_ff[3:0], rts_pkg::nibble_of(c)};

   always_comb begin
      mode_in             = mode_ff;
      letter_count_in     = letter_count_ff;
      name_match_in       = name_match_ff;
      param_accum_in      = param_accum_ff;
      param_negative_in   = param_negative_ff;
      digits_seen_in      = digits_seen_ff;
      hex_accum_in        = hex_accum_ff;
      binary_remaining_in = binary_remaining_ff;
      tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_OPEN, 8'd0, 1'b0, 32'd0);
      tok_list[1] = rts_pkg::make_token(rts_pkg::KIND_OPEN, 8'd0, 1'b0, 32'd0);
      tok_count = 2'd0;
      do_finish = 1'b0;
      do_idle   = 1'b0;
      do_bin    = 1'b0;
      bin_base  = binary_remaining_ff;
      bin_left  = 31'd0;

      case (mode_ff)
         rts_pkg::MODE_ESC: begin
            if (at_end) begin
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else if (rts_pkg::is_letter(c)) begin
               letter_count_in   = rts_pkg::LETTER_COUNT_WIDTH'(1);
               name_match_in     = (c == rts_pkg::CHAR_B) ? 2'd1 : 2'd0;
               param_accum_in    = 32'd0;
               param_negative_in = 1'b0;
               digits_seen_in    = 1'b0;
               mode_in           = rts_pkg::MODE_WORD;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_LETTER, c, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else if (c == rts_pkg::CHAR_QUOTE) begin
               hex_accum_in = 8'd0;
               mode_in      = rts_pkg::MODE_HEX1;
            end else begin
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_SYMBOL, c, 1'b0, 32'd0);
               tok_count = 2'd1;
            end
         end
         rts_pkg::MODE_WORD: begin
            if (at_end) begin
               do_finish = 1'b1;
            end else if (rts_pkg::is_letter(c) &&
                         (int'(letter_count_ff) < rts_pkg::MAX_NAME_LETTERS)) begin
               if ((int'(letter_count_ff) < 3) && (name_match_ff == 2'(letter_count_ff)) &&
                   (c == rts_pkg::bin_letter(2'(letter_count_ff)))) begin
                  name_match_in = name_match_ff + 2'd1;
               end
               letter_count_in = letter_count_ff + rts_pkg::LETTER_COUNT_WIDTH'(1);
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_LETTER, c, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else if (c == rts_pkg::CHAR_MINUS) begin
               param_negative_in = 1'b1;
               mode_in = rts_pkg::MODE_NEG;
            end else if (rts_pkg::is_digit(c)) begin
               param_accum_in = digit_accum;
               digits_seen_in = 1'b1;
               mode_in = rts_pkg::MODE_DIGITS;
            end else begin
               do_finish = 1'b1;
            end
         end
         rts_pkg::MODE_NEG: begin
            if (at_end) begin
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else if (rts_pkg::is_digit(c)) begin
               param_accum_in = digit_accum;
               digits_seen_in = 1'b1;
               mode_in = rts_pkg::MODE_DIGITS;
            end else begin
               do_finish = 1'b1;
            end
         end
         rts_pkg::MODE_DIGITS: begin
            if (!at_end && rts_pkg::is_digit(c)) begin
               param_accum_in = digit_accum;
               digits_seen_in = 1'b1;
            end else begin
               do_finish = 1'b1;
            end
         end
         rts_pkg::MODE_HEX1: begin
            if (at_end) begin
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else begin
               hex_accum_in = {4'd0, rts_pkg::nibble_of(c)};
               mode_in = rts_pkg::MODE_HEX2;
            end
         end
         rts_pkg::MODE_HEX2: begin
            hex_accum_in = hex_value;
            mode_in = rts_pkg::MODE_IDLE;
            tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_HEX, hex_value, 1'b1,
                                              {24'd0, hex_value});
            tok_count = 2'd1;
         end
         rts_pkg::MODE_BIN: begin
            if (at_end) begin
               binary_remaining_in = 31'd0;
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else begin
               do_bin = 1'b1;
            end
         end
         default: begin
            if (at_end) begin
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0, 32'd0);
               tok_count = 2'd1;
            end else begin
               do_idle = 1'b1;
            end
         end
      endcase

      // word end, then a delimiter other than a space goes on as a fresh byte
      if (do_finish) begin
         tok_list[0] = rts_pkg::make_token(rts_pkg::KIND_WEND, 8'd0, digits_seen_ff,
                                           word_value);
         tok_count = 2'd1;
         if (is_bin_word && !param_negative_ff && (param_accum_ff != 32'd0)) begin
            if (at_end) begin
               binary_remaining_in = 31'd0;
               mode_in = rts_pkg::MODE_IDLE;
               tok_list[1] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0, 32'd0);
               tok_count = 2'd2;
            end else begin
               binary_remaining_in = bin_start;
               mode_in = rts_pkg::MODE_BIN;
               bin_base = bin_start;
               do_bin = (c != rts_pkg::CHAR_SPACE);
            end
         end else begin
            mode_in = rts_pkg::MODE_IDLE;
            do_idle = !at_end && (c != rts_pkg::CHAR_SPACE);
         end
      end

      if (do_bin) begin
         bin_left = (bin_base != 31'd0) ? (bin_base - 31'd1) : 31'd0;
         binary_remaining_in = bin_left;
         mode_in = (bin_left == 31'd0) ? rts_pkg::MODE_IDLE : rts_pkg::MODE_BIN;
         tok_list[tok_count[0]] = rts_pkg::make_token(rts_pkg::KIND_BINARY, c, 1'b0, 32'd0);
         tok_count = tok_count + 2'd1;
      end

      if (do_idle) begin
         mode_in = rts_pkg::MODE_IDLE;
         if ((c == rts_pkg::CHAR_LF) || (c == rts_pkg::CHAR_CR)) begin
            mode_in = rts_pkg::MODE_IDLE;
         end else if (c == rts_pkg::CHAR_BACKSLASH) begin
            mode_in = rts_pkg::MODE_ESC;
         end else begin
            if (c == rts_pkg::CHAR_OPEN) begin
               tok_list[tok_count[0]] = rts_pkg::make_token(rts_pkg::KIND_OPEN, 8'd0, 1'b0,
                                                            32'd0);
            end else if (c == rts_pkg::CHAR_CLOSE) begin
               tok_list[tok_count[0]] = rts_pkg::make_token(rts_pkg::KIND_CLOSE, 8'd0, 1'b0,
                                                            32'd0);
            end else begin
               tok_list[tok_count[0]] = rts_pkg::make_token(rts_pkg::KIND_TEXT, c, 1'b0,
                                                            32'd0);
            end
            tok_count = tok_count + 2'd1;
         end
      end

      if (tok_count == 2'd2) begin
         tok_list[1].last_of_run = 1'b1;
      end else begin
         tok_list[0].last_of_run = 1'b1;
      end
   end

   assign push_valid              = accept && (tok_count != 2'd0);
   assign push_entry.two_tokens   = tok_count[1];
   assign push_entry.first_token  = tok_list[0];
   assign push_entry.second_token = tok_list[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rts_pkg::MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         letter_count_ff     <= letter_count_in;
         name_match_ff       <= name_match_in;
         param_accum_ff      <= param_accum_in;
         param_negative_ff   <= param_negative_in;
         digits_seen_ff      <= digits_seen_in;
         hex_accum_ff        <= hex_accum_in;
         binary_remaining_ff <= binary_remaining_in;
      end
   end

endmodule

// ----- hw/rtl/rts_queue.sv -----
// rts_queue: short register queue of token pairs between front and back
// depends on rts_pkg
module rts_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  rts_pkg::queue_entry_type  push_entry,
   input  logic                      pop_valid,
   output rts_pkg::queue_entry_type  pop_entry,
   output rts_pkg::queue_status_type status
);

   rts_pkg::queue_entry_type                entries_ff [rts_pkg::QUEUE_DEPTH];
   logic [rts_pkg::QUEUE_PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rts_pkg::QUEUE_PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rts_pkg::QUEUE_COUNT_WIDTH-1:0]   count_ff, count_in;

   localparam logic [rts_pkg::QUEUE_PTR_WIDTH-1:0] LAST_PTR =
      rts_pkg::QUEUE_PTR_WIDTH'(rts_pkg::QUEUE_DEPTH - 1);
   localparam logic [rts_pkg::QUEUE_COUNT_WIDTH-1:0] FULL_COUNT =
      rts_pkg::QUEUE_COUNT_WIDTH'(rts_pkg::QUEUE_DEPTH);

   assign pop_entry    = entries_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_COUNT);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 :
                     (wr_ptr_ff + rts_pkg::QUEUE_PTR_WIDTH'(1));
      end
      if (pop_valid) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 :
                     (rd_ptr_ff + rts_pkg::QUEUE_PTR_WIDTH'(1));
      end
      if (push_valid && !pop_valid) begin
         count_in = count_ff + rts_pkg::QUEUE_COUNT_WIDTH'(1);
      end else if (!push_valid && pop_valid) begin
         count_in = count_ff - rts_pkg::QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/rts_back.sv -----
// rts_back: unpacks queued token pairs into single result transactions
// depends on rts_pkg; pops from rts_queue
module rts_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rts_pkg::queue_status_type queue_status,
   input  rts_pkg::queue_entry_type  pop_entry,
   output logic                      pop_valid,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rts_pkg::rsp_payload_type  rsp_data
);

   logic                     out_valid_ff, out_valid_in;
   rts_pkg::rsp_payload_type out_tok_ff, out_tok_in;
   logic                     pend_valid_ff, pend_valid_in;
   rts_pkg::rsp_payload_type pend_tok_ff, pend_tok_in;
   logic                     load;

   assign load      = !out_valid_ff || rsp_ready;
   assign pop_valid = load && !pend_valid_ff && !queue_status.empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_tok_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_tok_in    = out_tok_ff;
      pend_valid_in = pend_valid_ff;
      pend_tok_in   = pend_tok_ff;
      if (load) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_tok_in    = pend_tok_ff;
            pend_valid_in = 1'b0;
         end else if (!queue_status.empty) begin
            out_valid_in  = 1'b1;
            out_tok_in    = pop_entry.first_token;
            pend_valid_in = pop_entry.two_tokens;
            pend_tok_in   = pop_entry.second_token;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff  <= out_tok_in;
      pend_tok_ff <= pend_tok_in;
   end

   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("second token pending without a first token shown");

   a_pend_is_last: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_tok_ff.last_of_run && !out_tok_ff.last_of_run))
      else $error("token pair has wrong last_of_run marks");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (!queue_status.empty && !pend_valid_ff))
      else $error("pop from empty queue or while a token is pending");

endmodule

// ----- hw/rtl/rtf_token_scanner.sv -----
// rtf_token_scanner: top level of the byte-serial rtf tokenizer
// depends on rts_pkg, rts_front, rts_queue, rts_back
//
// Takes one byte of an rtf stream (or an end-of-input marker) per request
// transaction and returns group, control word, symbol, hex, text and binary
// tokens as response transactions. The front scanner takes one byte per
// cycle while the queue is not full; a byte that finishes a control word and
// also starts the next token yields two responses, which the back end sends
// one after the other. A four-entry queue between the scanner and the back
// end absorbs these, so the request side only stalls when the queue fills,
// i.e. when responses are produced faster than one per cycle or rsp_ready is
// held low. Tokens pass the queue, then the back end's output register.
module rtf_token_scanner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rts_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rts_pkg::rsp_payload_type rsp_data
);

   rts_pkg::queue_status_type queue_status;
   rts_pkg::queue_entry_type  push_entry;
   rts_pkg::queue_entry_type  pop_entry;
   logic                      push_valid;
   logic                      pop_valid;

   rts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   rts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   rts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_entry    (pop_entry),
      .pop_valid    (pop_valid),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
